// ===== hw/rtl/ptqa_pkg.sv =====
// Shared types and constants for the priority ticket queue with aging.
`default_nettype none

package ptqa_pkg;

  // Field widths
  localparam int FUNC_W   = 1;
  localparam int CLASS_W  = 3;
  localparam int TICKET_W = 16;
  localparam int TIME_W   = 32;
  localparam int KIND_W   = 2;
  localparam int PRIO_W   = 4;
  localparam int WAIT_W   = 16;

  // Configuration register file: four classes of priority and wait limit
  localparam int CFG_CLASSES = 4;
  localparam int CFG_KIDX_W  = 2;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_PRIO    = 1 << PRIO_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRIO0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO1 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO2 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO3 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT0 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT1 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT2 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT3 = 4'd7;

  // Reset values of the configuration registers
  localparam logic [WAIT_W-1:0] WAIT_RESET = 16'd900;

  // Request operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_CALL = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ADDED    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CALLED   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CLASS_W-1:0] class_number;
    logic [TIME_W-1:0]  now_seconds;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0]   result_kind;
    logic [CLASS_W-1:0]  served_class;
    logic [TICKET_W-1:0] ticket_number;
    logic                was_overdue;
  } rsp_t;

  // One queue entry held by a cell
  typedef struct packed {
    logic [CLASS_W-1:0]  cls;
    logic [TICKET_W-1:0] ticket;
    logic [TIME_W-1:0]   arrival;
  } entry_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef logic [CFG_CLASSES-1:0][PRIO_W-1:0] prio_tab_t;
  typedef logic [CFG_CLASSES-1:0][WAIT_W-1:0] wait_tab_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ptqa_cell.sv =====
// One queue cell: holds an entry, tests it for overdue and reports its priority.
`default_nettype none

module ptqa_cell (
  input  logic               clk,
  input  logic               rst,
  input  ptqa_pkg::cell_ctl_t ctl,
  input  ptqa_pkg::entry_t   new_entry,
  input  logic               next_valid,
  input  ptqa_pkg::entry_t   next_entry,
  input  logic [ptqa_pkg::TIME_W-1:0] now,
  input  ptqa_pkg::prio_tab_t prio_tab,
  input  ptqa_pkg::wait_tab_t wait_tab,
  output logic               valid,
  output ptqa_pkg::entry_t   entry,
  output logic               overdue,
  output logic [ptqa_pkg::PRIO_W-1:0] prio
);
  import ptqa_pkg::*;

  logic [CLASS_W-1:0]    cls_m1;
  logic [CFG_KIDX_W-1:0] kidx;
  logic [TIME_W-1:0]     wait_time;

  // Hold the valid flag; take the neighbor's contents on removal
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= next_valid;
    end else if (ctl.load) begin
      valid <= 1'b1;
    end
  end

  // Hold the entry payload
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry <= next_entry;
    end else if (ctl.load) begin
      entry <= new_entry;
    end
  end

  // Look up class settings and test the wait against the limit
  always_comb begin
    cls_m1    = entry.cls - CLASS_W'(1);
    kidx      = cls_m1[CFG_KIDX_W-1:0];
    wait_time = now - entry.arrival;
    prio      = prio_tab[kidx];
    overdue   = valid && (wait_time >= {{(TIME_W-WAIT_W){1'b0}}, wait_tab[kidx]});
  end

endmodule

`default_nettype wire

// ===== hw/rtl/priority_ticket_queue_with_aging.sv =====
// Top level of the priority ticket queue with aging: sequencer, config and cell chain.
`default_nettype none

// A request is taken when start is high and busy is low. For an add, a rejected add and a
// call on an empty queue the result strobes on done in the cycle after it is taken.
// A call on a non-empty queue passes the evaluate and pick states: the cells test every
// entry for overdue and report its priority in parallel, the evaluate state registers the
// candidate set, and the pick state selects the first candidate in arrival order and closes
// the gap by shifting every later cell one place toward the head. done is high for exactly
// one cycle per request and the result is valid only in that cycle; it cannot be held off.
// Configuration writes are always ready and should be issued only while the block is idle.
module priority_ticket_queue_with_aging #(
  parameter int CAPACITY = 16,
  parameter int CLASSES  = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  ptqa_pkg::req_t                     request,
  output logic                               done,
  output ptqa_pkg::rsp_t                     result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ptqa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptqa_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ptqa_pkg::*;

  localparam int FILL_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_PICK} state_t;

  state_t                state;
  logic [FILL_W-1:0]     fill;
  logic [TIME_W-1:0]     now_q;
  logic [CAPACITY-1:0]   cand_vec;
  logic                  use_od;
  logic [TICKET_W-1:0]   ctr [CLASSES];
  prio_tab_t             prio_tab;
  wait_tab_t             wait_tab;

  // Cell chain signals
  logic [CAPACITY-1:0]   cell_valid;
  entry_t                cell_entry [CAPACITY];
  logic [CAPACITY-1:0]   cell_od;
  logic [PRIO_W-1:0]     cell_prio [CAPACITY];
  cell_ctl_t             cell_ctl [CAPACITY];
  entry_t                new_entry;

  // Request decode
  logic                  accept;
  logic                  is_add;
  logic                  cls_ok;
  logic                  full;
  logic                  add_ok;
  logic [CLASS_W-1:0]    req_m1;
  logic [TICKET_W-1:0]   ctr_cur;
  logic [TICKET_W-1:0]   ticket_new;

  // Selection
  logic [NUM_PRIO-1:0][CAPACITY-1:0] match;
  logic [NUM_PRIO-1:0]   have;
  logic [NUM_PRIO-1:0]   min_oh;
  logic [CAPACITY-1:0]   pri_cand;
  logic [CAPACITY-1:0]   cand_next;
  logic [CAPACITY-1:0]   sel;
  logic [CAPACITY-1:0]   ge_mask;
  entry_t                pick_entry;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Decode the request and fetch the class ticket counter
  always_comb begin
    is_add  = (request.func == FUNC_ADD);
    cls_ok  = (request.class_number >= CLASS_W'(1)) &&
              (request.class_number <= CLASS_W'(CLASSES));
    full    = (fill == FILL_W'(CAPACITY));
    add_ok  = cls_ok && !full;
    req_m1  = request.class_number - CLASS_W'(1);
    ctr_cur = '0;
    for (int c = 0; c < CLASSES; c++) begin
      if (req_m1[CFG_KIDX_W-1:0] == CFG_KIDX_W'(c)) begin
        ctr_cur = ctr[c];
      end
    end
    ticket_new          = ctr_cur + TICKET_W'(1);
    new_entry.cls       = request.class_number;
    new_entry.ticket    = ticket_new;
    new_entry.arrival   = request.now_seconds;
  end

  // Build the candidate set: overdue entries, else entries of the lowest priority
  always_comb begin
    for (int p = 0; p < NUM_PRIO; p++) begin
      for (int i = 0; i < CAPACITY; i++) begin
        match[p][i] = cell_valid[i] && (cell_prio[i] == PRIO_W'(p));
      end
      have[p] = |match[p];
    end
    min_oh   = have & (~have + NUM_PRIO'(1));
    pri_cand = '0;
    for (int p = 0; p < NUM_PRIO; p++) begin
      if (min_oh[p]) begin
        pri_cand = pri_cand | match[p];
      end
    end
    cand_next = (|cell_od) ? cell_od : pri_cand;
  end

  // Pick the earliest candidate and mark the cells that close the gap
  always_comb begin
    sel        = cand_vec & (~cand_vec + CAPACITY'(1));
    ge_mask    = ~(sel - CAPACITY'(1));
    pick_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel[i]) begin
        pick_entry = pick_entry | cell_entry[i];
      end
    end
  end

  // Drive per-cell load and shift
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctl[i].load  = accept && is_add && add_ok && (fill == FILL_W'(i));
      cell_ctl[i].shift = (state == ST_PICK) && ge_mask[i];
    end
  end

  // Cell chain, each cell fed by its tail-side neighbor
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic   nb_valid;
    entry_t nb_entry;
    if (g == CAPACITY - 1) begin : g_last
      assign nb_valid = 1'b0;
      assign nb_entry = '0;
    end else begin : g_mid
      assign nb_valid = cell_valid[g+1];
      assign nb_entry = cell_entry[g+1];
    end
    ptqa_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (cell_ctl[g]),
      .new_entry  (new_entry),
      .next_valid (nb_valid),
      .next_entry (nb_entry),
      .now        (now_q),
      .prio_tab   (prio_tab),
      .wait_tab   (wait_tab),
      .valid      (cell_valid[g]),
      .entry      (cell_entry[g]),
      .overdue    (cell_od[g]),
      .prio       (cell_prio[g])
    );
  end

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CFG_CLASSES; c++) begin
        prio_tab[c] <= PRIO_W'(c);
        wait_tab[c] <= WAIT_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRIO0: prio_tab[0] <= cfg_data[PRIO_W-1:0];
        REG_PRIO1: prio_tab[1] <= cfg_data[PRIO_W-1:0];
        REG_PRIO2: prio_tab[2] <= cfg_data[PRIO_W-1:0];
        REG_PRIO3: prio_tab[3] <= cfg_data[PRIO_W-1:0];
        REG_WAIT0: wait_tab[0] <= cfg_data[WAIT_W-1:0];
        REG_WAIT1: wait_tab[1] <= cfg_data[WAIT_W-1:0];
        REG_WAIT2: wait_tab[2] <= cfg_data[WAIT_W-1:0];
        REG_WAIT3: wait_tab[3] <= cfg_data[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequence requests and register results
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      done     <= 1'b0;
      result   <= '0;
      use_od   <= 1'b0;
      cand_vec <= '0;
      now_q    <= '0;
      for (int c = 0; c < CLASSES; c++) begin
        ctr[c] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          done <= accept && (is_add || (fill == '0));
          if (accept) begin
            now_q <= request.now_seconds;
            if (is_add) begin
              if (add_ok) begin
                for (int c = 0; c < CLASSES; c++) begin
                  if (req_m1[CFG_KIDX_W-1:0] == CFG_KIDX_W'(c)) begin
                    ctr[c] <= ticket_new;
                  end
                end
                fill   <= fill + FILL_W'(1);
                result <= '{result_kind: KIND_ADDED, served_class: request.class_number,
                            ticket_number: ticket_new, was_overdue: 1'b0};
              end else begin
                result <= '{result_kind: KIND_REJECTED, served_class: '0,
                            ticket_number: '0, was_overdue: 1'b0};
              end
            end else if (fill == '0) begin
              result <= '{result_kind: KIND_EMPTY, served_class: '0,
                          ticket_number: '0, was_overdue: 1'b0};
            end else begin
              state <= ST_EVAL;
            end
          end
        end
        ST_EVAL: begin
          done     <= 1'b0;
          cand_vec <= cand_next;
          use_od   <= |cell_od;
          state    <= ST_PICK;
        end
        ST_PICK: begin
          done   <= 1'b1;
          result <= '{result_kind: KIND_CALLED, served_class: pick_entry.cls,
                      ticket_number: pick_entry.ticket, was_overdue: use_od};
          fill   <= fill - FILL_W'(1);
          state  <= ST_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Occupied cells stay packed at the head and match the fill count
  a_packed: assert property (@(posedge clk) disable iff (rst)
    ($countones(cell_valid) == int'(fill)) && ((cell_valid & (cell_valid + CAPACITY'(1))) == '0))
    else $error("cell chain not compacted or fill count out of step");

  // A pick always removes exactly one occupied cell
  a_pick_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK) |-> ($onehot(sel) && ((sel & cell_valid) == sel)))
    else $error("pick selects no single occupied cell");

  // A call on a non-empty queue delivers its result right after the pick
  a_pick_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK) |=> (done && (result.result_kind == KIND_CALLED)))
    else $error("pick did not deliver a called result");

  // Never more entries than cells
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(CAPACITY))
    else $error("fill count beyond capacity");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the priority ticket queue with aging.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptqa_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int CLASS_COUNT  = 4;
  localparam int CLASS_MIN    = 1;
  localparam int CLASS_TOP    = (1 << CLASS_W) - 1;
  localparam int IDX_TOP      = (1 << CFG_IDX_W) - 1;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;
  localparam int PAIR_COUNT   = 10;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  req_t                  request;
  logic                  done;
  rsp_t                  result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  priority_ticket_queue_with_aging #(
    .CAPACITY(QUEUE_DEPTH),
    .CLASSES (CLASS_COUNT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow of the queue contents, ticket counters and class settings
  entry_t              lobby[$];
  logic [TICKET_W-1:0] tickets_issued[CFG_CLASSES];
  prio_tab_t           class_rank;
  wait_tab_t           class_patience;

  rsp_t                outcomes_due[$];
  int                  fault_count;
  int                  idle_cycles;
  logic [TIME_W-1:0]   wall_clock;
  int                  tick_span;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Work out the outcome of one request and advance the shadow state
  function automatic rsp_t next_outcome(req_t r);
    rsp_t                  o;
    int                    pick;
    logic                  overdue;
    logic [PRIO_W-1:0]     best;
    logic [CFG_KIDX_W-1:0] k;
    logic [TIME_W-1:0]     age;
    o = '0;
    pick = -1;
    overdue = 1'b0;
    if (r.func == FUNC_ADD) begin
      if (r.class_number < CLASS_MIN || r.class_number > CLASS_COUNT ||
          lobby.size() >= QUEUE_DEPTH) begin
        o.result_kind = KIND_REJECTED;
      end else begin
        k = CFG_KIDX_W'(r.class_number - CLASS_MIN);
        tickets_issued[k] = tickets_issued[k] + 1'b1;
        lobby.insert(lobby.size(), entry_t'{cls: r.class_number, ticket: tickets_issued[k],
                                            arrival: r.now_seconds});
        o.result_kind   = KIND_ADDED;
        o.served_class  = r.class_number;
        o.ticket_number = tickets_issued[k];
      end
    end else if (lobby.size() == 0) begin
      o.result_kind = KIND_EMPTY;
    end else begin
      // Oldest overdue entry wins
      foreach (lobby[i]) begin
        k = CFG_KIDX_W'(lobby[i].cls - CLASS_MIN);
        age = r.now_seconds - lobby[i].arrival;
        if (pick < 0 && age >= TIME_W'(class_patience[k])) begin
          pick = i;
          overdue = 1'b1;
        end
      end
      // Otherwise lowest rank, earliest arrival on a tie
      if (pick < 0) begin
        pick = 0;
        best = class_rank[CFG_KIDX_W'(lobby[0].cls - CLASS_MIN)];
        foreach (lobby[i]) begin
          k = CFG_KIDX_W'(lobby[i].cls - CLASS_MIN);
          if (class_rank[k] < best) begin
            best = class_rank[k];
            pick = i;
          end
        end
      end
      o.result_kind   = KIND_CALLED;
      o.served_class  = lobby[pick].cls;
      o.ticket_number = lobby[pick].ticket;
      o.was_overdue   = overdue;
      lobby.delete(pick);
    end
    return o;
  endfunction

  task automatic report_fault(string what, rsp_t want, rsp_t got);
    fault_count++;
    if (fault_count <= REPORT_LIMIT)
      $display("%0t %s: expected kind %0d class %0d ticket %0d overdue %0d, %s",
               $time, what, want.result_kind, want.served_class, want.ticket_number,
               want.was_overdue,
               $sformatf("got kind %0d class %0d ticket %0d overdue %0d",
                         got.result_kind, got.served_class, got.ticket_number,
                         got.was_overdue));
  endtask

  // Compare each strobed result with the oldest outstanding expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (outcomes_due.size() == 0) begin
        report_fault("unexpected result", '0, result);
      end else begin
        want = outcomes_due.pop_front();
        if (result.result_kind !== want.result_kind ||
            result.served_class !== want.served_class ||
            result.ticket_number !== want.ticket_number ||
            result.was_overdue !== want.was_overdue)
          report_fault("result mismatch", want, result);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold start and the request until accepted, then log the expected outcome
  task automatic send_request(req_t r);
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    outcomes_due.insert(outcomes_due.size(), next_outcome(r));
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drop start and let every outstanding request finish
  task automatic wait_idle();
    start <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers, then one write to an unused index
  task automatic apply_settings(prio_tab_t ranks, wait_tab_t limits);
    logic [CFG_DATA_W-1:0] word;
    wait_idle();
    for (int i = 0; i < 2 * CFG_CLASSES; i++) begin
      word = CFG_DATA_W'($urandom);
      if (i < CFG_CLASSES) begin
        word[PRIO_W-1:0] = ranks[i];
        cfg_index <= CFG_IDX_W'(REG_PRIO0 + i);
      end else begin
        word = limits[i - CFG_CLASSES];
        cfg_index <= CFG_IDX_W'(REG_WAIT0 + i - CFG_CLASSES);
      end
      cfg_valid <= 1'b1;
      cfg_data  <= word;
      do @(posedge clk); while (!cfg_ready);
      if (i < CFG_CLASSES) class_rank[i] = word[PRIO_W-1:0];
      else class_patience[i - CFG_CLASSES] = word;
    end
    cfg_index <= CFG_IDX_W'($urandom_range(IDX_TOP, REG_WAIT3 + 1));
    cfg_data  <= CFG_DATA_W'($urandom);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly time-ordered traffic with valid classes, some bad classes and raw noise
  function automatic req_t random_item(int add_pct);
    req_t r;
    int   v;
    if ($urandom_range(0, 99) < 12) begin
      r.func         = FUNC_W'($urandom);
      r.class_number = CLASS_W'($urandom);
      r.now_seconds  = TIME_W'($urandom);
    end else begin
      wall_clock     = wall_clock + $urandom_range(0, tick_span);
      r.func         = ($urandom_range(0, 99) < add_pct) ? FUNC_ADD : FUNC_CALL;
      r.now_seconds  = wall_clock;
      if ($urandom_range(0, 19) == 0) begin
        v = $urandom_range(CLASS_COUNT, CLASS_TOP);
        r.class_number = (v == CLASS_COUNT) ? '0 : CLASS_W'(v);
      end else begin
        r.class_number = CLASS_W'($urandom_range(CLASS_MIN, CLASS_COUNT));
      end
    end
    return r;
  endfunction

  task automatic run_burst(int count, int add_pct, bit gaps);
    for (int n = 0; n < count; n++) begin
      send_request(random_item(add_pct));
      pause(gaps ? gap_length() : 0);
    end
  endtask

  // Reset settings: empty call, bad classes, wrap of the wait, the equal-wait
  // boundary, priority order and equal tickets in different classes
  task automatic test_directed();
    send_request('{FUNC_CALL, CLASS_W'(CLASS_TOP), TIME_W'(0)});
    send_request('{FUNC_ADD, CLASS_W'(0), TIME_W'(0)});
    send_request('{FUNC_ADD, CLASS_W'(CLASS_COUNT + 1), TIME_W'(0)});
    send_request('{FUNC_ADD, CLASS_W'(CLASS_TOP), TIME_W'(0)});
    send_request('{FUNC_ADD, CLASS_W'(4), '1});
    send_request('{FUNC_ADD, CLASS_W'(3), TIME_W'(0)});
    send_request('{FUNC_ADD, CLASS_W'(2), TIME_W'(10)});
    send_request('{FUNC_ADD, CLASS_W'(1), TIME_W'(20)});
    send_request('{FUNC_CALL, CLASS_W'(0), TIME_W'(30)});
    send_request('{FUNC_CALL, CLASS_W'(0), TIME_W'(896)});
    send_request('{FUNC_CALL, CLASS_W'(0), TIME_W'(900)});
    send_request('{FUNC_CALL, CLASS_W'(0), TIME_W'(900)});
    send_request('{FUNC_CALL, CLASS_W'(0), TIME_W'(900)});
    send_request('{FUNC_ADD, CLASS_W'(1), TIME_W'(1000)});
    send_request('{FUNC_ADD, CLASS_W'(2), TIME_W'(1000)});
    send_request('{FUNC_CALL, CLASS_W'(0), TIME_W'(1000)});
    send_request('{FUNC_CALL, CLASS_W'(0), TIME_W'(1000)});
  endtask

  // Zero wait limits so every entry is overdue, the largest wait limits, and a mix of the two
  task automatic test_extreme_settings();
    prio_tab_t ranks;
    wait_tab_t limits;
    for (int s = 0; s < 3; s++) begin
      case (s)
        0: begin
          ranks  = '0;
          limits = '0;
        end
        1: begin
          ranks  = '1;
          limits = '1;
        end
        default: begin
          for (int c = 0; c < CFG_CLASSES; c++) begin
            ranks[c]  = c[0] ? '0 : '1;
            limits[c] = c[0] ? '1 : '0;
          end
        end
      endcase
      apply_settings(ranks, limits);
      wall_clock = $urandom;
      tick_span  = $urandom_range(0, 50);
      run_burst(60, 60, 1'b1);
    end
  endtask

  // Random settings, alternating fill and drain pressure
  task automatic test_random_traffic();
    prio_tab_t ranks;
    wait_tab_t limits;
    for (int p = 0; p < 8; p++) begin
      for (int c = 0; c < CFG_CLASSES; c++) begin
        ranks[c]  = p[0] ? PRIO_W'($urandom_range(0, 1)) : PRIO_W'($urandom);
        limits[c] = (p == 5) ? WAIT_W'($urandom) : WAIT_W'($urandom_range(0, 1200));
      end
      apply_settings(ranks, limits);
      wall_clock = $urandom;
      tick_span  = $urandom_range(1, 150);
      run_burst(100, p[0] ? 40 : 70, p != 3);
    end
  endtask

  // Empty the queue, then add and call back to back on one class
  task automatic test_add_call_pairs();
    wait_idle();
    while (lobby.size() != 0)
      send_request('{FUNC_CALL, CLASS_W'(0), wall_clock});
    repeat (PAIR_COUNT) begin
      send_request('{FUNC_ADD, CLASS_W'(CLASS_MIN), wall_clock});
      send_request('{FUNC_CALL, CLASS_W'(0), wall_clock});
    end
  endtask

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    request     <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    wall_clock  = '0;
    tick_span   = 1;
    for (int c = 0; c < CFG_CLASSES; c++) begin
      tickets_issued[c] = '0;
      class_rank[c]     = PRIO_W'(c);
      class_patience[c] = WAIT_RESET;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_extreme_settings();
    test_random_traffic();
    test_add_call_pairs();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && outcomes_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== priority_ticket_queue_with_aging.f =====
hw/rtl/ptqa_pkg.sv
hw/rtl/ptqa_cell.sv
hw/rtl/priority_ticket_queue_with_aging.sv
dv/tb.sv
